FILE: rtl/core/spa_pkg.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder package
// Shared types, operation codes and the saturating coefficient add.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int COEFF_W = 32;
    localparam int EXPO_PORT_W = 16;

    typedef enum logic [1:0] {
        OP_LOAD_FIRST,
        OP_LOAD_SECOND,
        OP_LOAD_MERGE
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_head;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PRIME,
        ST_MERGE
    } t_back_state;

    function automatic logic [COEFF_W-1:0] sat_add(
        input logic [COEFF_W-1:0] a,
        input logic [COEFF_W-1:0] b
    );
        logic [COEFF_W:0] s;
        s = {a[COEFF_W-1], a} + {b[COEFF_W-1], b};
        if (s[COEFF_W] != s[COEFF_W-1]) begin
            return s[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
        end
        return s[COEFF_W-1:0];
    endfunction

endpackage

FILE: rtl/core/spa_front.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder front end
// Accepts input transactions, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module spa_front #(
    parameter int EW = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic signed [31:0]            i_coeff,
    input  logic [EW-1:0]                 i_expo,
    input  logic                          i_last,
    output spa_pkg::t_head                o_head,
    output logic [spa_pkg::COEFF_W-1:0]   o_head_coeff,
    output logic [EW-1:0]                 o_head_expo,
    input  logic                          i_pop
);
    import spa_pkg::*;

    localparam int DEPTH = 2;

    t_op              r_op    [DEPTH];
    logic [COEFF_W-1:0] r_coeff [DEPTH];
    logic [EW-1:0]    r_expo  [DEPTH];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             push;
    logic             pop;
    t_op              in_op;

    always_comb begin
        if (!i_command) begin
            in_op = OP_LOAD_FIRST;
        end else if (i_last) begin
            in_op = OP_LOAD_MERGE;
        end else begin
            in_op = OP_LOAD_SECOND;
        end
    end

    assign o_in_stall = (r_count == 2'(DEPTH));
    assign push = i_in_valid && !o_in_stall;
    assign pop  = i_pop && (r_count != 2'd0);

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wr_ptr]    <= in_op;
            r_coeff[r_wr_ptr] <= i_coeff;
            r_expo[r_wr_ptr]  <= i_expo;
        end
    end

    assign o_head.valid  = (r_count != 2'd0);
    assign o_head.op     = r_op[r_rd_ptr];
    assign o_head_coeff  = r_coeff[r_rd_ptr];
    assign o_head_expo   = r_expo[r_rd_ptr];

endmodule

FILE: rtl/core/spa_back.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder back end
// Stores both term lists, merges them and drives the result register.
// ----------------------------------------------------------------------------
module spa_back #(
    parameter int T  = 32,
    parameter int EW = 16,
    parameter int CW = 6,
    parameter int IW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spa_pkg::t_head                i_head,
    input  logic [spa_pkg::COEFF_W-1:0]   i_head_coeff,
    input  logic [EW-1:0]                 i_head_expo,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [spa_pkg::COEFF_W-1:0]   o_sum_coeff,
    output logic [EW-1:0]                 o_sum_expo,
    output logic                          o_end_of_sum,
    output logic                          o_empty_res,
    output logic                          o_overflow
);
    import spa_pkg::*;

    localparam int MW = COEFF_W + EW;
    localparam logic [CW-1:0] CAP = CW'(T);

    logic [MW-1:0]      r_mem_a [T];
    logic [MW-1:0]      r_mem_b [T];
    logic [MW-1:0]      r_rd_a;
    logic [MW-1:0]      r_rd_b;

    t_back_state        r_state, n_state;
    logic [CW-1:0]      r_cnt_a, n_cnt_a;
    logic [CW-1:0]      r_cnt_b, n_cnt_b;
    logic [CW-1:0]      r_ia, n_ia;
    logic [CW-1:0]      r_ib, n_ib;
    logic               r_drop, n_drop;
    logic               r_pend_valid, n_pend_valid;
    logic [COEFF_W-1:0] r_pend_coeff, n_pend_coeff;
    logic [EW-1:0]      r_pend_expo, n_pend_expo;
    logic               r_out_valid, n_out_valid;
    logic [COEFF_W-1:0] r_out_coeff, n_out_coeff;
    logic [EW-1:0]      r_out_expo, n_out_expo;
    logic               r_out_end, n_out_end;
    logic               r_out_empty, n_out_empty;
    logic               r_out_ovf, n_out_ovf;

    logic               wr_a;
    logic               wr_b;
    logic               load_out;
    logic               out_free;
    logic               a_av;
    logic               b_av;
    logic [EW-1:0]      ea;
    logic [EW-1:0]      eb;
    logic [COEFF_W-1:0] ca;
    logic [COEFF_W-1:0] cb;
    logic [COEFF_W-1:0] sum;
    logic               take_a;
    logic               take_b;
    logic               res_valid;
    logic [COEFF_W-1:0] res_coeff;
    logic [EW-1:0]      res_expo;
    logic               finish;

    assign out_free = !r_out_valid || !i_out_stall;
    assign a_av = (r_ia < r_cnt_a);
    assign b_av = (r_ib < r_cnt_b);
    assign ea   = r_rd_a[EW-1:0];
    assign eb   = r_rd_b[EW-1:0];
    assign ca   = r_rd_a[MW-1:EW];
    assign cb   = r_rd_b[MW-1:EW];
    assign sum  = sat_add(ca, cb);

    // Merge step decision on the current list heads.
    always_comb begin
        take_a    = 1'b0;
        take_b    = 1'b0;
        res_valid = 1'b0;
        res_coeff = ca;
        res_expo  = ea;
        finish    = 1'b0;
        if (a_av && b_av) begin
            if (ea < eb) begin
                take_b    = 1'b1;
                res_valid = 1'b1;
                res_coeff = cb;
                res_expo  = eb;
            end else if (ea > eb) begin
                take_a    = 1'b1;
                res_valid = 1'b1;
            end else begin
                take_a    = 1'b1;
                take_b    = 1'b1;
                res_valid = (sum != '0);
                res_coeff = sum;
            end
        end else if (a_av) begin
            take_a    = 1'b1;
            res_valid = 1'b1;
        end else if (b_av) begin
            take_b    = 1'b1;
            res_valid = 1'b1;
            res_coeff = cb;
            res_expo  = eb;
        end else begin
            finish = 1'b1;
        end
    end

    always_comb begin
        o_pop        = 1'b0;
        wr_a         = 1'b0;
        wr_b         = 1'b0;
        load_out     = 1'b0;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_drop       = r_drop;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_pend_valid = r_pend_valid;
        n_pend_coeff = r_pend_coeff;
        n_pend_expo  = r_pend_expo;
        n_out_coeff  = r_out_coeff;
        n_out_expo   = r_out_expo;
        n_out_end    = r_out_end;
        n_out_empty  = r_out_empty;
        n_out_ovf    = r_out_ovf;
        case (r_state)
            ST_LOAD: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.op == OP_LOAD_FIRST) begin
                        if (r_cnt_a < CAP) begin
                            wr_a    = 1'b1;
                            n_cnt_a = r_cnt_a + CW'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else begin
                        if (r_cnt_b < CAP) begin
                            wr_b    = 1'b1;
                            n_cnt_b = r_cnt_b + CW'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                end
            end
            ST_PRIME: begin
            end
            ST_MERGE: begin
                if (out_free) begin
                    if (finish) begin
                        load_out     = 1'b1;
                        n_out_end    = 1'b1;
                        n_out_ovf    = r_drop;
                        n_out_empty  = !r_pend_valid;
                        n_out_coeff  = r_pend_valid ? r_pend_coeff : '0;
                        n_out_expo   = r_pend_valid ? r_pend_expo : '0;
                        n_pend_valid = 1'b0;
                        n_cnt_a      = '0;
                        n_cnt_b      = '0;
                        n_drop       = 1'b0;
                        n_ia         = '0;
                        n_ib         = '0;
                    end else begin
                        n_ia = r_ia + CW'(take_a);
                        n_ib = r_ib + CW'(take_b);
                        if (res_valid) begin
                            if (r_pend_valid) begin
                                load_out    = 1'b1;
                                n_out_end   = 1'b0;
                                n_out_empty = 1'b0;
                                n_out_ovf   = r_drop;
                                n_out_coeff = r_pend_coeff;
                                n_out_expo  = r_pend_expo;
                            end
                            n_pend_valid = 1'b1;
                            n_pend_coeff = res_coeff;
                            n_pend_expo  = res_expo;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_out_valid = load_out || (r_out_valid && i_out_stall);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_head.valid && i_head.op == OP_LOAD_MERGE) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (out_free && finish) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ia         <= '0;
            r_ib         <= '0;
            r_drop       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_ia         <= n_ia;
            r_ib         <= n_ib;
            r_drop       <= n_drop;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_coeff <= n_pend_coeff;
        r_pend_expo  <= n_pend_expo;
        r_out_coeff  <= n_out_coeff;
        r_out_expo   <= n_out_expo;
        r_out_end    <= n_out_end;
        r_out_empty  <= n_out_empty;
        r_out_ovf    <= n_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[r_cnt_a[IW-1:0]] <= {i_head_coeff, i_head_expo};
        end
        r_rd_a <= r_mem_a[n_ia[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_mem_b[r_cnt_b[IW-1:0]] <= {i_head_coeff, i_head_expo};
        end
        r_rd_b <= r_mem_b[n_ib[IW-1:0]];
    end

    assign o_out_valid  = r_out_valid;
    assign o_sum_coeff  = r_out_coeff;
    assign o_sum_expo   = r_out_expo;
    assign o_end_of_sum = r_out_end;
    assign o_empty_res  = r_out_empty;
    assign o_overflow   = r_out_ovf;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CAP) && (r_cnt_b <= CAP))
        else $error("term count exceeds list capacity");

    a_pop_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_LOAD))
        else $error("queue popped outside the load phase");

    a_pend_in_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == ST_MERGE))
        else $error("held result outside the merge phase");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_end && r_out_coeff == '0))
        else $error("empty result is not a zero final term");

    a_merge_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE && n_state == ST_LOAD) |=>
            (r_cnt_a == '0 && r_cnt_b == '0 && !r_drop && r_out_valid && r_out_end))
        else $error("merge completion did not clear the lists");

endmodule

FILE: rtl/core/sparse_polynomial_adder.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder
// Adds two sparse polynomials loaded as descending term lists.
// ----------------------------------------------------------------------------
// Input transactions carry one term each: command 0 appends to the first
// list, command 1 to the second. A second-list term with last set starts the
// merge. Output transactions carry the sum's terms in descending exponent
// order, the final one flagged by end_of_sum; a fully cancelled sum gives a
// single transaction with empty_res set and zero term fields.
// A two-entry queue sits between input and the list store. In the load phase
// the back end stores each term it pops. After the closing term is stored, a
// prime state primes the list head reads, then the merge runs one step per
// cycle while the output is free (at most first count plus second count
// steps) and a closing step; a result leaves through the output register in
// the cycle after the step that releases it. The memory read port of each
// list sets this pace. When the receiver stalls, the output register holds
// and the merge waits; the queue keeps accepting input until it is full.
// Reset empties the queue and both lists and clears the dropped-term flag.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder #(
    parameter int TERMS_PER_POLY = 32,
    parameter int EXPO_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic signed [31:0] i_coeff,
    input  logic [15:0] i_expo,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_sum_coeff,
    output logic [15:0] o_sum_expo,
    output logic        o_end_of_sum,
    output logic        o_empty_res,
    output logic        o_overflow
);
    import spa_pkg::*;

    localparam int EW = (EXPO_BITS < EXPO_PORT_W) ? EXPO_BITS : EXPO_PORT_W;
    localparam int CW = $clog2(TERMS_PER_POLY + 1);
    localparam int IW = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;

    t_head              head;
    logic [COEFF_W-1:0] head_coeff;
    logic [EW-1:0]      head_expo;
    logic               pop;
    logic [COEFF_W-1:0] sum_coeff;
    logic [EW-1:0]      sum_expo;

    spa_front #(
        .EW (EW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_coeff      (i_coeff),
        .i_expo       (i_expo[EW-1:0]),
        .i_last       (i_last),
        .o_head       (head),
        .o_head_coeff (head_coeff),
        .o_head_expo  (head_expo),
        .i_pop        (pop)
    );

    spa_back #(
        .T  (TERMS_PER_POLY),
        .EW (EW),
        .CW (CW),
        .IW (IW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_coeff (head_coeff),
        .i_head_expo  (head_expo),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sum_coeff  (sum_coeff),
        .o_sum_expo   (sum_expo),
        .o_end_of_sum (o_end_of_sum),
        .o_empty_res  (o_empty_res),
        .o_overflow   (o_overflow)
    );

    assign o_sum_coeff = sum_coeff;
    assign o_sum_expo  = EXPO_PORT_W'(sum_expo);

endmodule
